>>> rtl/dmsd_pkg.sv
`timescale 1ns / 1ps

package dmsd_pkg;

    localparam int unsigned POWER_W  = 8;
    localparam int unsigned TARGET_W = 9;

    // command codes; code 3 is unused and leaves all state as it is
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_BRAKE = 2'd2;

    localparam logic [POWER_W-1:0] FULL_DUTY       = 8'hFF;
    localparam logic [POWER_W-1:0] RAMP_STEP_RESET = 8'd1;

    // per-lane strobes, already qualified by the accepted word
    typedef struct packed {
        logic                 load;
        logic                 tick;
        logic                 brake;
        logic                 braking_next;
        logic [POWER_W-1:0]   ramp_step;
    } lane_ctrl_t;

    // what one lane reports for the state after the word
    typedef struct packed {
        logic                 dir;
        logic [POWER_W-1:0]   duty;
        logic                 at_goal;
    } lane_stat_t;

endpackage

>>> rtl/dmsd_if.sv
`timescale 1ns / 1ps

interface dmsd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            operation;
    logic signed [dmsd_pkg::TARGET_W-1:0]  left_target;
    logic signed [dmsd_pkg::TARGET_W-1:0]  right_target;

    modport source (output valid, output operation, output left_target,
                    output right_target, input ready);
    modport sink   (input valid, input operation, input left_target,
                    input right_target, output ready);
endinterface

interface dmsd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            left_dir;
    logic [dmsd_pkg::POWER_W-1:0]    left_duty;
    logic                            right_dir;
    logic [dmsd_pkg::POWER_W-1:0]    right_duty;
    logic                            settled;

    modport source (output valid, output left_dir, output left_duty,
                    output right_dir, output right_duty, output settled,
                    input ready);
    modport sink   (input valid, input left_dir, input left_duty,
                    input right_dir, input right_duty, input settled,
                    output ready);
endinterface

interface dmsd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dmsd_pkg::POWER_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/dmsd_lane.sv
`timescale 1ns / 1ps

module dmsd_lane
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmsd_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [dmsd_pkg::TARGET_W-1:0] target,
    output dmsd_pkg::lane_stat_t                 stat
);

    logic [dmsd_pkg::POWER_W-1:0]  power_reg, power_next;
    logic [dmsd_pkg::POWER_W-1:0]  goal_reg, goal_next;
    logic                          fwd_reg, fwd_next;

    logic                          target_fwd;
    logic [dmsd_pkg::TARGET_W-1:0] target_abs;
    logic [dmsd_pkg::POWER_W-1:0]  target_mag;
    logic [dmsd_pkg::POWER_W-1:0]  gap_up, gap_down;
    logic [dmsd_pkg::POWER_W-1:0]  ramped;

    // strictly positive is forward; saturate the magnitude of -256
    assign target_fwd = !target[dmsd_pkg::TARGET_W-1] && (target != '0);
    assign target_abs = target[dmsd_pkg::TARGET_W-1] ? (~target + 1'b1) : target;
    assign target_mag = target_abs[dmsd_pkg::TARGET_W-1] ? dmsd_pkg::FULL_DUTY
                                                         : target_abs[dmsd_pkg::POWER_W-1:0];

    assign gap_up   = goal_reg - power_reg;
    assign gap_down = power_reg - goal_reg;

    // step toward the goal, clamp at it
    always_comb
    begin
        if (power_reg < goal_reg)
        begin
            ramped = (gap_up > ctrl.ramp_step) ? power_reg + ctrl.ramp_step : goal_reg;
        end
        else if (power_reg > goal_reg)
        begin
            ramped = (gap_down > ctrl.ramp_step) ? power_reg - ctrl.ramp_step : goal_reg;
        end
        else
        begin
            ramped = power_reg;
        end
    end

    always_comb
    begin
        power_next = power_reg;
        goal_next  = goal_reg;
        fwd_next   = fwd_reg;
        if (ctrl.load)
        begin
            goal_next = target_mag;
            fwd_next  = target_fwd;
            if (target_fwd != fwd_reg)
            begin
                power_next = '0;
            end
        end
        else if (ctrl.tick)
        begin
            power_next = ramped;
        end
        else if (ctrl.brake)
        begin
            power_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= '0;
            goal_reg  <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            power_reg <= power_next;
            goal_reg  <= goal_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_comb
    begin
        stat.dir     = ctrl.braking_next || fwd_next;
        stat.at_goal = (power_next == goal_next);
        if (ctrl.braking_next)
        begin
            stat.duty = dmsd_pkg::FULL_DUTY;
        end
        else if (fwd_next)
        begin
            stat.duty = dmsd_pkg::FULL_DUTY - power_next;
        end
        else
        begin
            stat.duty = power_next;
        end
    end

`ifndef SYNTH
    a_brake_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.brake && !ctrl.load && !ctrl.tick |=> power_reg == '0)
        else $error("power not zero after brake");

    a_reverse_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load && (target_fwd != fwd_reg) |=> power_reg == '0)
        else $error("power not zero after direction change");

    a_no_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.tick && !ctrl.load && (power_reg <= goal_reg) |=> power_reg <= goal_reg)
        else $error("ramp passed the goal");
`endif

endmodule

>>> rtl/dmsd_merge.sv
`timescale 1ns / 1ps

module dmsd_merge
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  dmsd_pkg::lane_stat_t left,
    input  dmsd_pkg::lane_stat_t right,
    output logic                 space,
    dmsd_out_if.source           result
);

    logic                          valid_reg, valid_next;
    logic                          left_dir_reg, right_dir_reg, settled_reg;
    logic [dmsd_pkg::POWER_W-1:0]  left_duty_reg, right_duty_reg;

    // the register frees up in the same cycle the held word is taken
    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: load on take, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_dir_reg   <= left.dir;
            left_duty_reg  <= left.duty;
            right_dir_reg  <= right.dir;
            right_duty_reg <= right.duty;
            settled_reg    <= left.at_goal && right.at_goal;
        end
    end

    assign result.valid      = valid_reg;
    assign result.left_dir   = left_dir_reg;
    assign result.left_duty  = left_duty_reg;
    assign result.right_dir  = right_dir_reg;
    assign result.right_duty = right_duty_reg;
    assign result.settled    = settled_reg;

endmodule

>>> rtl/dual_motor_soft_start_driver.sv
`timescale 1ns / 1ps

// Two-channel H-bridge drive with slew-limited power. Each word on cmd is a
// set (load signed targets), a tick (move each power one ramp_step toward its
// goal) or a brake (zero both powers, all pins high until the next set); every
// word yields exactly one result word on result showing direction level and
// duty per channel plus a settled flag, for the state after that word. The
// block takes one word per clock unless the result stalls: both lanes update
// their state in the cycle the word is accepted, and the result lands in a
// single output register, which the accept loads. A stalled result holds
// the output register, and cmd.ready then follows result.ready, so a word is
// still taken in the very cycle the held result leaves. ramp_step is written
// through cfg, which is always ready; write it only while the block is idle.

module dual_motor_soft_start_driver
(
    input  logic      clk,
    input  logic      rst_n,
    dmsd_in_if.sink   cmd,
    dmsd_cfg_if.sink  cfg,
    dmsd_out_if.source result
);

    logic                           take;
    logic                           space;
    logic                           braking_reg, braking_next;
    logic [dmsd_pkg::POWER_W-1:0]   ramp_step_reg;
    logic                           is_set, is_tick, is_brake;
    dmsd_pkg::lane_ctrl_t           ctrl;
    dmsd_pkg::lane_stat_t           left_stat, right_stat;

    // accept a command word whenever the output register can take its result
    assign cmd.ready = space;
    assign take      = cmd.valid && space;
    assign cfg.ready = 1'b1;

    // decode the command; the unused code changes nothing
    always_comb
    begin
        is_set   = 1'b0;
        is_tick  = 1'b0;
        is_brake = 1'b0;
        case (cmd.operation)
            dmsd_pkg::OP_SET:   is_set   = 1'b1;
            dmsd_pkg::OP_TICK:  is_tick  = 1'b1;
            dmsd_pkg::OP_BRAKE: is_brake = 1'b1;
            default:            ;
        endcase
    end

    // brake latches until the next set; ticks are dropped while braking
    always_comb
    begin
        braking_next = braking_reg;
        if (take && is_set)
        begin
            braking_next = 1'b0;
        end
        else if (take && is_brake)
        begin
            braking_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            braking_reg   <= 1'b0;
            ramp_step_reg <= dmsd_pkg::RAMP_STEP_RESET;
        end
        else
        begin
            braking_reg <= braking_next;
            if (cfg.valid)
            begin
                ramp_step_reg <= cfg.data;
            end
        end
    end

    always_comb
    begin
        ctrl.load         = take && is_set;
        ctrl.tick         = take && is_tick && !braking_reg;
        ctrl.brake        = take && is_brake;
        ctrl.braking_next = braking_next;
        ctrl.ramp_step    = ramp_step_reg;
    end

    // one lane per bridge, same control, own target
    dmsd_lane u_left
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .target (cmd.left_target),
        .stat   (left_stat)
    );

    dmsd_lane u_right
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .target (cmd.right_target),
        .stat   (right_stat)
    );

    // combine the lanes into the result word and hold it for the sink
    dmsd_merge u_merge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .left   (left_stat),
        .right  (right_stat),
        .space  (space),
        .result (result)
    );

endmodule

>>> sim/dmsd_duty_checker.sv
`timescale 1ns / 1ps

module dmsd_duty_checker
(
    input  logic        clk,
    input  logic        rst_n,
    dmsd_in_if          cmd,
    dmsd_cfg_if         cfg,
    dmsd_out_if         result,
    output int unsigned failures,
    output int unsigned pending
);

    typedef struct packed {
        logic                         fwd;
        logic [dmsd_pkg::POWER_W-1:0] power;
        logic [dmsd_pkg::POWER_W-1:0] goal;
    } lane_t;

    typedef struct packed {
        logic                         left_dir;
        logic [dmsd_pkg::POWER_W-1:0] left_duty;
        logic                         right_dir;
        logic [dmsd_pkg::POWER_W-1:0] right_duty;
        logic                         settled;
    } drive_word_t;

    lane_t                        left_lane;
    lane_t                        right_lane;
    logic                         braking;
    logic [dmsd_pkg::POWER_W-1:0] step_size;
    drive_word_t                  drive_q[$];
    drive_word_t                  want;
    drive_word_t                  got;
    int unsigned                  fail_count = 0;
    int unsigned                  backlog;

    assign failures = fail_count;
    assign pending  = backlog;

    // load one target: saturate the magnitude, zero the power on a reversal
    function automatic lane_t lane_load(lane_t ln,
                                       logic signed [dmsd_pkg::TARGET_W-1:0] target);
        int    t;
        int    mag;
        lane_t nx;
        t   = int'(target);
        mag = (t < 0) ? -t : t;
        if (mag > 255)
            mag = 255;
        nx     = ln;
        nx.fwd = (t > 0);
        if (nx.fwd != ln.fwd)
            nx.power = '0;
        nx.goal = mag[dmsd_pkg::POWER_W-1:0];
        return nx;
    endfunction

    // step power toward goal, never past it
    function automatic logic [dmsd_pkg::POWER_W-1:0] slew(lane_t ln,
                                                          logic [dmsd_pkg::POWER_W-1:0] step);
        int p;
        int g;
        int s;
        p = int'(ln.power);
        g = int'(ln.goal);
        s = int'(step);
        if (p < g)
            return ((g - p) > s) ? dmsd_pkg::POWER_W'(p + s) : ln.goal;
        if (p > g)
            return ((p - g) > s) ? dmsd_pkg::POWER_W'(p - s) : ln.goal;
        return ln.power;
    endfunction

    function automatic logic [dmsd_pkg::POWER_W-1:0] duty_of(lane_t ln, logic brk);
        if (brk)
            return dmsd_pkg::FULL_DUTY;
        return ln.fwd ? dmsd_pkg::FULL_DUTY - ln.power : ln.power;
    endfunction

    task automatic flag(string field, int exp_v, int act_v);
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_lane  = '0;
            right_lane = '0;
            braking    = 1'b0;
            step_size  = dmsd_pkg::RAMP_STEP_RESET;
            drive_q.delete();
            backlog    <= 0;
        end
        else
        begin
            // compare first: the word leaving now was predicted at an earlier edge
            if (result.valid && result.ready)
            begin
                got = '{result.left_dir, result.left_duty, result.right_dir,
                        result.right_duty, result.settled};
                if (drive_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.left_dir !== want.left_dir)
                        flag("left_dir", int'(want.left_dir), int'(got.left_dir));
                    if (got.left_duty !== want.left_duty)
                        flag("left_duty", int'(want.left_duty), int'(got.left_duty));
                    if (got.right_dir !== want.right_dir)
                        flag("right_dir", int'(want.right_dir), int'(got.right_dir));
                    if (got.right_duty !== want.right_duty)
                        flag("right_duty", int'(want.right_duty), int'(got.right_duty));
                    if (got.settled !== want.settled)
                        flag("settled", int'(want.settled), int'(got.settled));
                end
            end

            if (cfg.valid && cfg.ready)
                step_size = cfg.data;

            if (cmd.valid && cmd.ready)
            begin
                case (cmd.operation)
                    dmsd_pkg::OP_SET:
                    begin
                        left_lane  = lane_load(left_lane, cmd.left_target);
                        right_lane = lane_load(right_lane, cmd.right_target);
                        braking    = 1'b0;
                    end
                    dmsd_pkg::OP_TICK:
                        if (!braking)
                        begin
                            left_lane.power  = slew(left_lane, step_size);
                            right_lane.power = slew(right_lane, step_size);
                        end
                    dmsd_pkg::OP_BRAKE:
                    begin
                        left_lane.power  = '0;
                        right_lane.power = '0;
                        braking          = 1'b1;
                    end
                    default: ;
                endcase
                want.left_dir   = braking | left_lane.fwd;
                want.left_duty  = duty_of(left_lane, braking);
                want.right_dir  = braking | right_lane.fwd;
                want.right_duty = duty_of(right_lane, braking);
                want.settled    = (left_lane.power == left_lane.goal) &&
                                  (right_lane.power == right_lane.goal);
                drive_q.push_back(want);
            end

            backlog <= unsigned'(drive_q.size());
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam time         CLK_PERIOD   = 12ns;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned HOLD_AT      = 150;   // words sent before the long stall
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned PHASE_WORDS  = 81;
    localparam logic [1:0]  OP_SPARE     = 2'd3;  // unused code, must leave state alone

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycles = 0;
    int unsigned words_sent;
    int unsigned burst_left;
    int unsigned failures;
    int unsigned pending;

    dmsd_in_if  cmd();
    dmsd_cfg_if cfg();
    dmsd_out_if result();

    dual_motor_soft_start_driver i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .result (result)
    );

    dmsd_duty_checker u_duty_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: end the run if the handshakes ever lock up.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one command word. The sender runs in bursts: when a burst is used
    // up, drop valid for a random gap (sometimes none) and start a new burst.
    // Return at the edge where the word is taken.
    task automatic offer_word(input logic [1:0] op,
                              input logic signed [dmsd_pkg::TARGET_W-1:0] lt,
                              input logic signed [dmsd_pkg::TARGET_W-1:0] rt);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd.valid        <= 1'b1;
        cmd.operation    <= op;
        cmd.left_target  <= lt;
        cmd.right_target <= rt;
        do @(posedge clk); while (!cmd.ready);
        words_sent++;
    endtask

    // Drop valid and hold until every predicted result word has been taken,
    // then let the output register settle.
    task automatic drain();
        cmd.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ramp(input logic [dmsd_pkg::POWER_W-1:0] step);
        cfg.valid <= 1'b1;
        cfg.data  <= step;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Mix corner values, small targets that settle quickly even with a
    // slow ramp, and the full signed range.
    function automatic logic signed [dmsd_pkg::TARGET_W-1:0] pick_target();
        logic signed [dmsd_pkg::TARGET_W-1:0] corners [7];
        int unsigned                          r;
        corners = '{-9'sd256, -9'sd255, -9'sd1, 9'sd0, 9'sd1, 9'sd254, 9'sd255};
        r = $urandom_range(0, 9);
        if (r < 2)
            return corners[3'($urandom_range(0, 6))];
        if (r < 6)
            return dmsd_pkg::TARGET_W'($urandom_range(0, 48)) - 9'sd24;
        return dmsd_pkg::TARGET_W'($urandom_range(0, 511));
    endfunction

    function automatic logic signed [dmsd_pkg::TARGET_W-1:0] noise();
        return dmsd_pkg::TARGET_W'($urandom_range(0, 511));
    endfunction

    // Random words: mostly a set followed by a run of ticks so the ramps get
    // somewhere, with brakes, spare codes and stray ticks as noise.
    task automatic random_phase(input int unsigned count);
        int unsigned n;
        int unsigned r;
        int unsigned ticks;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                offer_word(dmsd_pkg::OP_SET, pick_target(), pick_target());
                ticks = $urandom_range(1, 20);
                repeat (ticks) offer_word(dmsd_pkg::OP_TICK, noise(), noise());
                n += 1 + ticks;
            end
            else
            begin
                if (r < 88)
                    offer_word(dmsd_pkg::OP_TICK, noise(), noise());
                else if (r < 96)
                    offer_word(dmsd_pkg::OP_BRAKE, noise(), noise());
                else
                    offer_word(OP_SPARE, noise(), noise());
                n++;
            end
        end
    endtask

    // Receiver: stall on a random pattern, picked anew after each random stretch,
    // from always ready down to ready a quarter of the time. Once, hold ready low for a long
    // stretch so the output register fills and the block backs up cmd.
    initial
    begin
        int unsigned stall_mode;
        int unsigned stretch;
        bit          squeezed;
        stretch  = 0;
        squeezed = 1'b0;
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!squeezed && words_sent >= HOLD_AT)
            begin
                squeezed = 1'b1;
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (stretch == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    stretch    = $urandom_range(8, 40);
                end
                stretch--;
                case (stall_mode)
                    0:       result.ready <= 1'b1;
                    1:       result.ready <= 1'($urandom_range(0, 1));
                    2:       result.ready <= ($urandom_range(0, 3) == 0);
                    default: result.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [dmsd_pkg::POWER_W-1:0] ramp_plan [6];
        words_sent       = 0;
        burst_left       = 0;
        rst_n            <= 1'b0;
        cmd.valid        <= 1'b0;
        cmd.operation    <= dmsd_pkg::OP_SET;
        cmd.left_target  <= '0;
        cmd.right_target <= '0;
        cfg.valid        <= 1'b0;
        cfg.data         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset ramp step of one.
        offer_word(OP_SPARE, 9'sd0, 9'sd0);                  // report the reset state
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_SET, 9'sd255, -9'sd256);     // full forward, saturated reverse
        offer_word(dmsd_pkg::OP_TICK, -9'sd256, 9'sd255);
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_SET, -9'sd255, 9'sd255);     // both lanes reverse direction
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_SET, 9'sd0, 9'sd1);          // zero target means reverse
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_BRAKE, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);         // ignored while braking
        offer_word(OP_SPARE, -9'sd1, -9'sd1);
        offer_word(dmsd_pkg::OP_SET, -9'sd1, 9'sd0);         // release the brake
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_SET, -9'sd256, 9'sd255);
        offer_word(dmsd_pkg::OP_TICK, 9'sd0, 9'sd0);
        offer_word(dmsd_pkg::OP_BRAKE, 9'sd255, -9'sd256);
        drain();

        // Sweep the ramp step through its extremes, zero included, and a
        // couple of random settings; write it only with the block drained.
        ramp_plan = '{8'd255, 8'd0, 8'd1, dmsd_pkg::POWER_W'($urandom_range(2, 254)), 8'd128,
                      dmsd_pkg::POWER_W'($urandom_range(1, 16))};
        foreach (ramp_plan[i])
        begin
            write_ramp(ramp_plan[i]);
            random_phase(PHASE_WORDS);
            drain();
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/dmsd_pkg.sv
rtl/dmsd_if.sv
rtl/dmsd_lane.sv
rtl/dmsd_merge.sv
rtl/dual_motor_soft_start_driver.sv
sim/dmsd_duty_checker.sv
sim/tb.sv
